[design/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants of the priority mixer with collision flags.
// ----------------------------------------------------------------------------
package pmc_pkg;

    // lookup table and collision store geometry
    localparam int TAB_DEPTH  = 128;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int TAB_DW     = 4;
    localparam int COLL_DEPTH = 64;
    localparam int COLL_AW    = $clog2(COLL_DEPTH);

    // field widths
    localparam int REQ_W   = 3;
    localparam int SPR_W   = 9;
    localparam int LAYER_W = 11;
    localparam int DATA_W  = 9;
    localparam int PIX_W   = 11;
    localparam int RD_W    = 8;

    // config port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_SCREEN_BLANK = 3'd0;

    // filler bits of a collision read
    localparam logic [5:0] READ_ONES = 6'h3f;

    // table source codes (code 3 also picks the scrolling layer)
    localparam logic [1:0] SRC_SPRITE = 2'd0;
    localparam logic [1:0] SRC_FG     = 2'd1;
    localparam logic [1:0] SRC_BG     = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_MIX     = 3'd0,
        REQ_LOAD    = 3'd1,
        REQ_READ    = 3'd2,
        REQ_CLR_BIT = 3'd3,
        REQ_CLR_SUM = 3'd4
    } t_req_type;

    typedef struct packed {
        logic               en;
        logic [COLL_AW-1:0] addr;
    } t_coll_rd;

    typedef struct packed {
        logic               en;
        logic [COLL_AW-1:0] addr;
        logic               data;
    } t_coll_wr;

endpackage

[design/pmc_req_if.sv]
// ----------------------------------------------------------------------------
// pmc_req_if
// Request channel: valid/ready handshake and request payload.
// ----------------------------------------------------------------------------
interface pmc_req_if import pmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [SPR_W-1:0]     sprite_pixel;
    logic [LAYER_W-1:0]   fg_pixel;
    logic [LAYER_W-1:0]   bg_pixel;
    logic [COLL_AW-1:0]   collision_index;
    logic [TAB_AW-1:0]    table_index;
    logic [TAB_DW-1:0]    table_value;

    modport source (
        output valid, req_type, sprite_pixel, fg_pixel, bg_pixel,
               collision_index, table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, sprite_pixel, fg_pixel, bg_pixel,
               collision_index, table_index, table_value,
        output ready
    );
endinterface

[design/pmc_rsp_if.sv]
// ----------------------------------------------------------------------------
// pmc_rsp_if
// Result channel: valid/ready handshake and result payload.
// ----------------------------------------------------------------------------
interface pmc_rsp_if import pmc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_color;
    logic [RD_W-1:0]  read_data;

    modport source (
        output valid, pixel_color, read_data,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, read_data,
        output ready
    );
endinterface

[design/pmc_coll_store.sv]
// ----------------------------------------------------------------------------
// pmc_coll_store
// 64x1 collision flag memory, registered read, valid bits for reset clear,
// write-to-read forwarding for a same-edge write to the read entry.
// ----------------------------------------------------------------------------
module pmc_coll_store import pmc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_coll_rd i_rd,
    input  t_coll_wr i_wr,
    output logic     o_rd_bit
);

    logic                  r_mem [COLL_DEPTH];
    logic [COLL_DEPTH-1:0] r_valid;
    logic                  r_rd_data;
    logic                  r_rd_valid;
    logic                  r_fwd;
    logic                  r_fwd_bit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
            r_fwd_bit <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
                r_fwd      <= i_wr.en && (i_wr.addr == i_rd.addr);
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_bit = r_fwd ? r_fwd_bit : (r_rd_valid & r_rd_data);

endmodule

[design/priority_mixer_with_collision.sv]
// ----------------------------------------------------------------------------
// priority_mixer_with_collision
// Video priority mixer: table-driven layer select with sprite collision flags.
// ----------------------------------------------------------------------------
// Returns exactly one result per request, in order: the table access
// stage reads the 128x4 priority table and the collision flag memory into
// registers, and the result stage forms the result into the output
// register. Throughput is one request per clock while the output does not
// stall; a stalled output holds the pipeline and drops ready only when both
// the middle stage and the output register are full. Load the whole table
// before mixing: an entry never loaded gives an
// undefined pixel and collision. Collision flags and the summary clear at
// reset without a sweep (valid bits), so requests are taken right away.
// screen_blank (APB address 0) may be written only while no request is in
// flight.
// ----------------------------------------------------------------------------
module priority_mixer_with_collision import pmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmc_req_if.sink           i_req,
    pmc_rsp_if.source         o_rsp,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready
);

    // ---------------- configuration ----------------
    logic r_screen_blank;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_blank <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && (i_paddr == ADDR_SCREEN_BLANK)) begin
            r_screen_blank <= i_pwdata[0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr == ADDR_SCREEN_BLANK) begin
            o_prdata[0] = r_screen_blank;
        end
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;     // middle stage may move into the output register
    logic in_fire;

    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign in_fire     = i_req.valid && i_req.ready;

    // ---------------- stage 0: table access ----------------
    t_req_type         in_req;
    logic [TAB_AW-1:0] mix_idx;

    assign in_req = t_req_type'(i_req.req_type);

    // index: {bg prio, bg clear, fg prio, fg clear, sprite clear}
    assign mix_idx = {i_req.bg_pixel[10:9], (i_req.bg_pixel[2:0] == 3'd0),
                      i_req.fg_pixel[10:9], (i_req.fg_pixel[2:0] == 3'd0),
                      (i_req.sprite_pixel[3:0] == 4'd0)};

    logic [TAB_DW-1:0] r_tab [TAB_DEPTH];
    logic [TAB_DW-1:0] r_tab_q;

    // load and mix of successive requests never share an edge
    always_ff @(posedge i_clk) begin
        if (in_fire && (in_req == REQ_LOAD)) begin
            r_tab[i_req.table_index] <= i_req.table_value;
        end
        if (in_fire && (in_req == REQ_MIX)) begin
            r_tab_q <= r_tab[mix_idx];
        end
    end

    // stage 1 payload
    t_req_type          r_s1_req;
    logic [SPR_W-1:0]   r_s1_spr;
    logic [DATA_W-1:0]  r_s1_fg;
    logic [DATA_W-1:0]  r_s1_bg;
    logic [COLL_AW-1:0] r_s1_cidx;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req  <= in_req;
            r_s1_spr  <= i_req.sprite_pixel;
            r_s1_fg   <= i_req.fg_pixel[DATA_W-1:0];
            r_s1_bg   <= i_req.bg_pixel[DATA_W-1:0];
            r_s1_cidx <= i_req.collision_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // ---------------- collision store ----------------
    t_coll_rd coll_rd;
    t_coll_wr coll_wr;
    logic     coll_bit;
    logic     s1_fire;
    logic     mix_live;   // mix request with blanking off
    logic     coll_set;

    assign s1_fire  = r_s1_valid && s1_adv;
    assign mix_live = (r_s1_req == REQ_MIX) && !r_screen_blank;
    assign coll_set = mix_live && !r_tab_q[2];   // table bit 2 is active low

    // read issued with the request; held while the middle stage stalls
    assign coll_rd.en   = in_fire;
    assign coll_rd.addr = i_req.collision_index;

    always_comb begin
        coll_wr.en   = 1'b0;
        coll_wr.addr = r_s1_cidx;
        coll_wr.data = 1'b0;
        if (coll_set) begin
            coll_wr.en   = s1_fire;
            coll_wr.addr = {r_tab_q[3], r_s1_spr[SPR_W-1:4]};   // bank, sprite number
            coll_wr.data = 1'b1;
        end else if (r_s1_req == REQ_CLR_BIT) begin
            coll_wr.en   = s1_fire;
        end
    end

    pmc_coll_store u_coll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (coll_rd),
        .i_wr     (coll_wr),
        .o_rd_bit (coll_bit)
    );

    // summary flag: updated as the request leaves stage 1
    logic r_summary;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary <= 1'b0;
        end else if (s1_fire) begin
            if (coll_set) begin
                r_summary <= 1'b1;
            end else if (r_s1_req == REQ_CLR_SUM) begin
                r_summary <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: result ----------------
    logic [PIX_W-1:0] n_pixel;
    logic [RD_W-1:0]  n_rdata;

    always_comb begin
        n_pixel = '0;
        n_rdata = '0;
        unique case (r_s1_req)
            REQ_MIX: begin
                if (!r_screen_blank) begin
                    unique case (r_tab_q[1:0])
                        SRC_SPRITE: n_pixel = {SRC_SPRITE, r_s1_spr};
                        SRC_FG:     n_pixel = {SRC_FG, r_s1_fg};
                        default:    n_pixel = {SRC_BG, r_s1_bg};
                    endcase
                end
            end
            REQ_READ: n_rdata = {r_summary, READ_ONES, coll_bit};
            default:  ;   // load, clears and unused codes give zeros
        endcase
    end

    // ---------------- output register ----------------
    logic [PIX_W-1:0] r_out_pixel;
    logic [RD_W-1:0]  r_out_rdata;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_pixel <= n_pixel;
            r_out_rdata <= n_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.pixel_color = r_out_pixel;
    assign o_rsp.read_data   = r_out_rdata;

endmodule

[design/pmc_checker.sv]
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks of the priority mixer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pmc_checker import pmc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_pixel_color,
    input logic [RD_W-1:0]  i_read_data,
    input logic             i_pready
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_color) && $stable(i_read_data))
        else $error("result changed while stalled");

    // a result carries a pixel or a read value, never both
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pixel_color == '0) || (i_read_data == '0))
        else $error("pixel and read data both set");

    // read data always has its filler ones
    a_read_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_data != '0) |-> (i_read_data[6:1] == READ_ONES))
        else $error("malformed collision read");

    // pixel source select is never the unused code
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pixel_color[10:9] != 2'd3))
        else $error("bad pixel source select");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");

endmodule

bind priority_mixer_with_collision pmc_checker u_pmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_pixel_color (o_rsp.pixel_color),
    .i_read_data   (o_rsp.read_data),
    .i_pready      (o_pready)
);
